// ----- rtl/i2crts_pkg.sv -----
package i2crts_pkg;

   // Default depth of the write buffer, in bytes.
   localparam int BUFFER_DEPTH_DEF = 256;

   // Item function codes.
   localparam logic [1:0] FUNC_LOAD  = 2'd0;
   localparam logic [1:0] FUNC_WRITE = 2'd1;
   localparam logic [1:0] FUNC_READ  = 2'd2;
   localparam logic [1:0] FUNC_EVENT = 2'd3;

   // Bus actions handed to the byte engine.
   localparam logic [2:0] ACT_NONE  = 3'd0;
   localparam logic [2:0] ACT_START = 3'd1;
   localparam logic [2:0] ACT_STOP  = 3'd2;
   localparam logic [2:0] ACT_SEND  = 3'd3;
   localparam logic [2:0] ACT_RECV  = 3'd4;
   localparam logic [2:0] ACT_ACK   = 3'd5;
   localparam logic [2:0] ACT_NACK  = 3'd6;

   // Transfer status codes.
   localparam logic [1:0] ST_PENDING = 2'd0;
   localparam logic [1:0] ST_SUCCESS = 2'd1;
   localparam logic [1:0] ST_FAILED  = 2'd2;

   // Access to the write buffer, issued once per accepted item at most.
   typedef struct packed {
      logic       en;
      logic       we;
      logic [7:0] addr;
      logic [7:0] wdata;
   } buf_req_type;

endpackage

// ----- rtl/i2c_register_transfer_sequencer_top.sv -----
// I2C register transfer sequencer, sitting above a byte-level bus engine.
// The req_ channel carries one item per command: a write buffer load, a
// start of a register write or read, or a bus completion event with its
// NACK flag, collision flag and received byte. The rsp_ channel returns
// exactly one result item per request item: whether it was taken, the next
// bus action with its byte, any delivered read byte, and the transfer status.
// The result of an item accepted at one clock edge is presented right after
// that edge. Throughput is one item per clock while rsp_ready is high; it
// is set by the single output register and by the single-port write buffer,
// touched at most once per item (a load writes it, a data send reads it).
// The receiver may stall freely: while a result waits, req_ready stays high
// only if rsp_ready is high in the same cycle, so a new item moves in exactly
// as the waiting one leaves. Reset puts the sequencer idle with status
// success and empties the output register; the buffer contents are not
// cleared and must be loaded before a write sends them.
module i2c_register_transfer_sequencer_top #(
   parameter int BUFFER_DEPTH = i2crts_pkg::BUFFER_DEPTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_func,
   input  logic [6:0] req_slave_address,
   input  logic [7:0] req_register_address,
   input  logic [7:0] req_byte_count,
   input  logic [7:0] req_buffer_index,
   input  logic [7:0] req_write_byte,
   input  logic       req_nack_seen,
   input  logic       req_bus_collision,
   input  logic [7:0] req_received_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_accepted,
   output logic [2:0] rsp_bus_action,
   output logic [7:0] rsp_tx_byte,
   output logic       rsp_rx_valid,
   output logic [7:0] rsp_rx_index,
   output logic [7:0] rsp_rx_data,
   output logic [1:0] rsp_transfer_status
);

   i2crts_pkg::buf_req_type buf_req;
   logic [7:0]              rd_data;

   i2crts_ctrl #(
      .BUFFER_DEPTH(BUFFER_DEPTH)
   ) u_ctrl (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_func            (req_func),
      .req_slave_address   (req_slave_address),
      .req_register_address(req_register_address),
      .req_byte_count      (req_byte_count),
      .req_buffer_index    (req_buffer_index),
      .req_write_byte      (req_write_byte),
      .req_nack_seen       (req_nack_seen),
      .req_bus_collision   (req_bus_collision),
      .req_received_byte   (req_received_byte),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_accepted        (rsp_accepted),
      .rsp_bus_action      (rsp_bus_action),
      .rsp_tx_byte         (rsp_tx_byte),
      .rsp_rx_valid        (rsp_rx_valid),
      .rsp_rx_index        (rsp_rx_index),
      .rsp_rx_data         (rsp_rx_data),
      .rsp_transfer_status (rsp_transfer_status),
      .buf_req             (buf_req),
      .rd_data             (rd_data)
   );

   i2crts_wbuf #(
      .BUFFER_DEPTH(BUFFER_DEPTH)
   ) u_wbuf (
      .clock  (clock),
      .buf_req(buf_req),
      .rd_data(rd_data)
   );

endmodule

// ----- rtl/i2crts_wbuf.sv -----
module i2crts_wbuf #(
   parameter int BUFFER_DEPTH = i2crts_pkg::BUFFER_DEPTH_DEF
) (
   input  logic                    clock,
   input  i2crts_pkg::buf_req_type buf_req,
   output logic [7:0]              rd_data
);

   localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;

   logic [7:0] buffer_ff [BUFFER_DEPTH];
   logic [7:0] rd_data_ff;
   logic [AW-1:0] addr;

   assign addr = buf_req.addr[AW-1:0];

   // Single port: one item touches the buffer at most once. Read data holds
   // until the next read so a stalled result keeps its byte.
   always_ff @(posedge clock) begin
      if (buf_req.en) begin
         if (buf_req.we) begin
            buffer_ff[addr] <= buf_req.wdata;
         end else begin
            rd_data_ff <= buffer_ff[addr];
         end
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/i2crts_ctrl.sv -----
module i2crts_ctrl #(
   parameter int BUFFER_DEPTH = i2crts_pkg::BUFFER_DEPTH_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [1:0]              req_func,
   input  logic [6:0]              req_slave_address,
   input  logic [7:0]              req_register_address,
   input  logic [7:0]              req_byte_count,
   input  logic [7:0]              req_buffer_index,
   input  logic [7:0]              req_write_byte,
   input  logic                    req_nack_seen,
   input  logic                    req_bus_collision,
   input  logic [7:0]              req_received_byte,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic                    rsp_accepted,
   output logic [2:0]              rsp_bus_action,
   output logic [7:0]              rsp_tx_byte,
   output logic                    rsp_rx_valid,
   output logic [7:0]              rsp_rx_index,
   output logic [7:0]              rsp_rx_data,
   output logic [1:0]              rsp_transfer_status,
   output i2crts_pkg::buf_req_type buf_req,
   input  logic [7:0]              rd_data
);

   localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
   localparam logic [8:0] DEPTH9 = 9'(BUFFER_DEPTH);
   localparam logic [AW-1:0] PTR_LAST = AW'(BUFFER_DEPTH - 1);

   typedef enum logic [3:0] {
      PH_IDLE, PH_SEND_ADDR, PH_SEND_REG, PH_SEND_DATA, PH_RS_STOP, PH_RS_START,
      PH_READ_ADDR, PH_FIRST_RX, PH_RX_BYTE, PH_EN_RX, PH_NACK_DONE, PH_FAIL_END,
      PH_OK_END
   } phase_type;

   phase_type     phase_ff, phase_in;
   logic [1:0]    status_ff, status_in;
   logic [7:0]    addr_ff, addr_in;
   logic [7:0]    reg_ff, reg_in;
   logic [7:0]    count_ff, count_in;
   logic [7:0]    pos_ff, pos_in;
   logic          is_read_ff, is_read_in;
   logic [AW-1:0] ptr_ff, ptr_in;

   logic          valid_ff, valid_in;
   logic          acc_ff, acc_in;
   logic [2:0]    act_ff, act_in;
   logic [7:0]    tx_ff, tx_in;
   logic          use_mem_ff, use_mem_in;
   logic          rxv_ff, rxv_in;
   logic [7:0]    rxi_ff, rxi_in;
   logic [7:0]    rxd_ff, rxd_in;

   logic          accept;
   logic [7:0]    pos_inc;

   assign req_ready = !valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign pos_inc   = pos_ff + 8'd1;

   always_comb begin
      phase_in   = phase_ff;
      status_in  = status_ff;
      addr_in    = addr_ff;
      reg_in     = reg_ff;
      count_in   = count_ff;
      pos_in     = pos_ff;
      is_read_in = is_read_ff;
      ptr_in     = ptr_ff;
      valid_in   = valid_ff && !rsp_ready;
      acc_in     = acc_ff;
      act_in     = act_ff;
      tx_in      = tx_ff;
      use_mem_in = use_mem_ff;
      rxv_in     = rxv_ff;
      rxi_in     = rxi_ff;
      rxd_in     = rxd_ff;
      buf_req    = '{en: 1'b0, we: 1'b0, addr: req_buffer_index, wdata: req_write_byte};

      if (accept) begin
         valid_in   = 1'b1;
         acc_in     = 1'b0;
         act_in     = i2crts_pkg::ACT_NONE;
         tx_in      = 8'd0;
         use_mem_in = 1'b0;
         rxv_in     = 1'b0;
         rxi_in     = 8'd0;
         rxd_in     = 8'd0;

         unique case (req_func)
            i2crts_pkg::FUNC_LOAD: begin
               if ({1'b0, req_buffer_index} < DEPTH9) begin
                  buf_req.en = 1'b1;
                  buf_req.we = 1'b1;
                  acc_in     = 1'b1;
               end
            end
            i2crts_pkg::FUNC_WRITE, i2crts_pkg::FUNC_READ: begin
               if (phase_ff == PH_IDLE) begin
                  addr_in    = {req_slave_address, 1'b0};
                  reg_in     = req_register_address;
                  count_in   = req_byte_count;
                  pos_in     = 8'd0;
                  ptr_in     = '0;
                  is_read_in = (req_func == i2crts_pkg::FUNC_READ);
                  status_in  = i2crts_pkg::ST_PENDING;
                  phase_in   = PH_SEND_ADDR;
                  acc_in     = 1'b1;
                  act_in     = i2crts_pkg::ACT_START;
               end
            end
            default: begin
               if (phase_ff != PH_IDLE) begin
                  acc_in = 1'b1;
                  if (req_bus_collision) begin
                     act_in   = i2crts_pkg::ACT_STOP;
                     phase_in = PH_FAIL_END;
                  end else begin
                     unique case (phase_ff)
                        PH_SEND_ADDR: begin
                           act_in   = i2crts_pkg::ACT_SEND;
                           tx_in    = addr_ff;
                           phase_in = PH_SEND_REG;
                        end
                        PH_SEND_REG: begin
                           if (req_nack_seen) begin
                              act_in   = i2crts_pkg::ACT_STOP;
                              phase_in = PH_FAIL_END;
                           end else begin
                              act_in   = i2crts_pkg::ACT_SEND;
                              tx_in    = reg_ff;
                              phase_in = is_read_ff ? PH_RS_STOP : PH_SEND_DATA;
                           end
                        end
                        PH_SEND_DATA: begin
                           if (req_nack_seen) begin
                              act_in   = i2crts_pkg::ACT_STOP;
                              phase_in = PH_FAIL_END;
                           end else if (pos_ff < count_ff) begin
                              // The buffer read is registered, so the byte comes out with this result.
                              act_in       = i2crts_pkg::ACT_SEND;
                              use_mem_in   = 1'b1;
                              buf_req.en   = 1'b1;
                              buf_req.addr = 8'(ptr_ff);
                              pos_in       = pos_inc;
                              ptr_in       = (ptr_ff == PTR_LAST) ? '0 : ptr_ff + 1'b1;
                           end else begin
                              act_in   = i2crts_pkg::ACT_STOP;
                              phase_in = PH_OK_END;
                           end
                        end
                        PH_RS_STOP: begin
                           act_in   = i2crts_pkg::ACT_STOP;
                           phase_in = PH_RS_START;
                        end
                        PH_RS_START: begin
                           act_in   = i2crts_pkg::ACT_START;
                           phase_in = PH_READ_ADDR;
                        end
                        PH_READ_ADDR: begin
                           act_in   = i2crts_pkg::ACT_SEND;
                           tx_in    = addr_ff + 8'd1;
                           phase_in = PH_FIRST_RX;
                        end
                        PH_FIRST_RX: begin
                           if (req_nack_seen) begin
                              act_in   = i2crts_pkg::ACT_STOP;
                              phase_in = PH_FAIL_END;
                           end else begin
                              act_in   = i2crts_pkg::ACT_RECV;
                              phase_in = PH_RX_BYTE;
                           end
                        end
                        PH_RX_BYTE: begin
                           rxv_in = 1'b1;
                           rxi_in = pos_ff;
                           rxd_in = req_received_byte;
                           pos_in = pos_inc;
                           if (pos_inc < count_ff) begin
                              act_in   = i2crts_pkg::ACT_ACK;
                              phase_in = PH_EN_RX;
                           end else begin
                              act_in   = i2crts_pkg::ACT_NACK;
                              phase_in = PH_NACK_DONE;
                           end
                        end
                        PH_EN_RX: begin
                           act_in   = i2crts_pkg::ACT_RECV;
                           phase_in = PH_RX_BYTE;
                        end
                        PH_NACK_DONE: begin
                           act_in   = i2crts_pkg::ACT_STOP;
                           phase_in = PH_OK_END;
                        end
                        PH_FAIL_END: begin
                           status_in = i2crts_pkg::ST_FAILED;
                           phase_in  = PH_IDLE;
                        end
                        PH_OK_END: begin
                           status_in = i2crts_pkg::ST_SUCCESS;
                           phase_in  = PH_IDLE;
                        end
                        default: begin
                           status_in = i2crts_pkg::ST_FAILED;
                           phase_in  = PH_IDLE;
                        end
                     endcase
                  end
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         status_ff <= i2crts_pkg::ST_SUCCESS;
         valid_ff  <= 1'b0;
      end else begin
         phase_ff  <= phase_in;
         status_ff <= status_in;
         valid_ff  <= valid_in;
      end
      addr_ff    <= addr_in;
      reg_ff     <= reg_in;
      count_ff   <= count_in;
      pos_ff     <= pos_in;
      is_read_ff <= is_read_in;
      ptr_ff     <= ptr_in;
      acc_ff     <= acc_in;
      act_ff     <= act_in;
      tx_ff      <= tx_in;
      use_mem_ff <= use_mem_in;
      rxv_ff     <= rxv_in;
      rxi_ff     <= rxi_in;
      rxd_ff     <= rxd_in;
   end

   // Status rides with the result it belongs to, so it is captured at accept.
   logic [1:0] st_out_ff;
   always_ff @(posedge clock) begin
      if (accept) begin
         st_out_ff <= status_in;
      end
   end

   assign rsp_valid           = valid_ff;
   assign rsp_accepted        = acc_ff;
   assign rsp_bus_action      = act_ff;
   assign rsp_tx_byte         = use_mem_ff ? rd_data : tx_ff;
   assign rsp_rx_valid        = rxv_ff;
   assign rsp_rx_index        = rxi_ff;
   assign rsp_rx_data         = rxd_ff;
   assign rsp_transfer_status = st_out_ff;

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 100ps

// Checks the I2C register transfer sequencer item by item. Requests come from
// a short table of hand-picked cases first, then from a generator that mostly
// runs complete register writes and reads with random content. A few NACKs,
// collisions, refused starts, loads and stray events are mixed in. Every
// accepted request is run through a local model of the sequencer. The result
// it predicts waits in a queue until the matching response item arrives.
module testbench;

   // Sequencer phases of the local model.
   typedef enum logic [3:0] {
      SQ_IDLE, SQ_SEND_ADDR, SQ_SEND_REG, SQ_SEND_DATA, SQ_RS_STOP, SQ_RS_START,
      SQ_READ_ADDR, SQ_FIRST_RX, SQ_RX_BYTE, SQ_EN_RX, SQ_NACK_DONE, SQ_FAIL_END,
      SQ_OK_END
   } seq_phase_type;

   // One request item, in port order.
   typedef struct packed {
      logic [1:0] func;
      logic [6:0] saddr;
      logic [7:0] raddr;
      logic [7:0] cnt;
      logic [7:0] bidx;
      logic [7:0] wbyte;
      logic       nack;
      logic       coll;
      logic [7:0] rbyte;
   } cmd_type;

   // One response item, in port order.
   typedef struct packed {
      logic       acc;
      logic [2:0] act;
      logic [7:0] tx;
      logic       rxv;
      logic [7:0] rxi;
      logic [7:0] rxd;
      logic [1:0] st;
   } result_type;

   // A row of the directed table. Where given is set, the response is typed in
   // and compared as written; otherwise the model supplies it.
   typedef struct packed {
      cmd_type    cmd;
      logic       given;
      result_type res;
   } row_type;

   localparam int DIR_ROWS = 25;
   // The two longest transfers take about 1100 items between them, so they
   // come early and the run stops shortly after the second one ends.
   localparam int unsigned ITEM_TARGET = 1250;
   localparam int unsigned HOLD_OFF = 300;
   localparam int unsigned STALL_LIMIT = 3000;
   localparam int DRAIN_CYCLES = 8;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic req_valid = 1'b0;
   cmd_type req_cmd = '0;
   logic rsp_ready = 1'b0;

   logic       req_ready;
   logic       rsp_valid;
   logic       rsp_accepted;
   logic [2:0] rsp_bus_action;
   logic [7:0] rsp_tx_byte;
   logic       rsp_rx_valid;
   logic [7:0] rsp_rx_index;
   logic [7:0] rsp_rx_data;
   logic [1:0] rsp_transfer_status;

   // Local copy of the sequencer state.
   seq_phase_type mdl_phase;
   logic [1:0] mdl_status;
   logic [7:0] mdl_addr;
   logic [7:0] mdl_reg;
   logic [7:0] mdl_count;
   logic [7:0] mdl_pos;
   logic       mdl_read;
   logic [7:0] mdl_buffer [i2crts_pkg::BUFFER_DEPTH_DEF];

   result_type awaited_results [$];
   cmd_type upcoming [$];
   bit loaded [i2crts_pkg::BUFFER_DEPTH_DEF];
   row_type dir_table [DIR_ROWS];

   int unsigned table_pos = 0;
   int unsigned taken_items = 0;
   int unsigned transfer_count = 0;
   int unsigned send_gap = 0;
   int unsigned stall_left = 0;
   int unsigned results_seen = 0;
   int unsigned quiet_cycles = 0;
   int unsigned cycle_no = 0;
   logic cur_given = 1'b0;
   result_type cur_given_res = '0;
   logic held_off = 1'b0;
   logic no_idle = 1'b0;
   logic stim_done = 1'b0;
   logic failed = 1'b0;

   i2c_register_transfer_sequencer_top dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_func(req_cmd.func),
      .req_slave_address(req_cmd.saddr),
      .req_register_address(req_cmd.raddr),
      .req_byte_count(req_cmd.cnt),
      .req_buffer_index(req_cmd.bidx),
      .req_write_byte(req_cmd.wbyte),
      .req_nack_seen(req_cmd.nack),
      .req_bus_collision(req_cmd.coll),
      .req_received_byte(req_cmd.rbyte),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_accepted(rsp_accepted),
      .rsp_bus_action(rsp_bus_action),
      .rsp_tx_byte(rsp_tx_byte),
      .rsp_rx_valid(rsp_rx_valid),
      .rsp_rx_index(rsp_rx_index),
      .rsp_rx_data(rsp_rx_data),
      .rsp_transfer_status(rsp_transfer_status)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // Directed cases. A one byte write covers the address, register and data
   // bytes, a load of a slot while the transfer is pending, and refused starts.
   // A read of zero bytes still receives one byte and NACKs it, and a NACK on
   // the stop of the restart is ignored. A collision ends a write as failed.
   initial begin
      dir_table[0]  = '{'{i2crts_pkg::FUNC_EVENT, 7'h7F, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                          1'b1, 1'b1, 8'hFF},
                        1'b1, '{1'b0, i2crts_pkg::ACT_NONE, 8'h00, 1'b0, 8'h00, 8'h00,
                                i2crts_pkg::ST_SUCCESS}};
      dir_table[1]  = '{'{i2crts_pkg::FUNC_LOAD, 7'h00, 8'h00, 8'h00, 8'h00, 8'hFF,
                          1'b0, 1'b0, 8'h00},
                        1'b1, '{1'b1, i2crts_pkg::ACT_NONE, 8'h00, 1'b0, 8'h00, 8'h00,
                                i2crts_pkg::ST_SUCCESS}};
      dir_table[2]  = '{'{i2crts_pkg::FUNC_LOAD, 7'h00, 8'h00, 8'h00, 8'hFF, 8'h00,
                          1'b0, 1'b0, 8'h00},
                        1'b1, '{1'b1, i2crts_pkg::ACT_NONE, 8'h00, 1'b0, 8'h00, 8'h00,
                                i2crts_pkg::ST_SUCCESS}};
      dir_table[3]  = '{'{i2crts_pkg::FUNC_WRITE, 7'h7F, 8'hFF, 8'h01, 8'h00, 8'h00,
                          1'b0, 1'b0, 8'h00},
                        1'b1, '{1'b1, i2crts_pkg::ACT_START, 8'h00, 1'b0, 8'h00, 8'h00,
                                i2crts_pkg::ST_PENDING}};
      dir_table[4]  = '{'{i2crts_pkg::FUNC_WRITE, 7'h00, 8'h00, 8'hFF, 8'h00, 8'h00,
                          1'b0, 1'b0, 8'h00},
                        1'b1, '{1'b0, i2crts_pkg::ACT_NONE, 8'h00, 1'b0, 8'h00, 8'h00,
                                i2crts_pkg::ST_PENDING}};
      dir_table[5]  = '{'{i2crts_pkg::FUNC_READ, 7'h01, 8'h01, 8'h01, 8'h00, 8'h00,
                          1'b0, 1'b0, 8'h00},
                        1'b1, '{1'b0, i2crts_pkg::ACT_NONE, 8'h00, 1'b0, 8'h00, 8'h00,
                                i2crts_pkg::ST_PENDING}};
      dir_table[6]  = '{'{i2crts_pkg::FUNC_EVENT, 7'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                          1'b1, 1'b0, 8'h00},
                        1'b1, '{1'b1, i2crts_pkg::ACT_SEND, 8'hFE, 1'b0, 8'h00, 8'h00,
                                i2crts_pkg::ST_PENDING}};
      dir_table[7]  = '{'{i2crts_pkg::FUNC_EVENT, 7'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                          1'b0, 1'b0, 8'h00},
                        1'b1, '{1'b1, i2crts_pkg::ACT_SEND, 8'hFF, 1'b0, 8'h00, 8'h00,
                                i2crts_pkg::ST_PENDING}};
      dir_table[8]  = '{'{i2crts_pkg::FUNC_LOAD, 7'h00, 8'h00, 8'h00, 8'h00, 8'hA5,
                          1'b0, 1'b0, 8'h00},
                        1'b1, '{1'b1, i2crts_pkg::ACT_NONE, 8'h00, 1'b0, 8'h00, 8'h00,
                                i2crts_pkg::ST_PENDING}};
      dir_table[9]  = '{'{i2crts_pkg::FUNC_EVENT, 7'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                          1'b0, 1'b0, 8'h00},
                        1'b0, '0};
      dir_table[10] = '{'{i2crts_pkg::FUNC_EVENT, 7'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                          1'b0, 1'b0, 8'h00},
                        1'b0, '0};
      dir_table[11] = '{'{i2crts_pkg::FUNC_EVENT, 7'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                          1'b0, 1'b0, 8'h00},
                        1'b1, '{1'b1, i2crts_pkg::ACT_NONE, 8'h00, 1'b0, 8'h00, 8'h00,
                                i2crts_pkg::ST_SUCCESS}};
      dir_table[12] = '{'{i2crts_pkg::FUNC_READ, 7'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                          1'b0, 1'b0, 8'h00},
                        1'b1, '{1'b1, i2crts_pkg::ACT_START, 8'h00, 1'b0, 8'h00, 8'h00,
                                i2crts_pkg::ST_PENDING}};
      dir_table[13] = '{'{i2crts_pkg::FUNC_EVENT, 7'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                          1'b1, 1'b0, 8'h00},
                        1'b0, '0};
      dir_table[14] = '{'{i2crts_pkg::FUNC_EVENT, 7'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                          1'b0, 1'b0, 8'h00},
                        1'b0, '0};
      dir_table[15] = '{'{i2crts_pkg::FUNC_EVENT, 7'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                          1'b1, 1'b0, 8'h00},
                        1'b1, '{1'b1, i2crts_pkg::ACT_STOP, 8'h00, 1'b0, 8'h00, 8'h00,
                                i2crts_pkg::ST_PENDING}};
      dir_table[16] = '{'{i2crts_pkg::FUNC_EVENT, 7'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                          1'b0, 1'b0, 8'h00},
                        1'b0, '0};
      dir_table[17] = '{'{i2crts_pkg::FUNC_EVENT, 7'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                          1'b0, 1'b0, 8'h00},
                        1'b0, '0};
      dir_table[18] = '{'{i2crts_pkg::FUNC_EVENT, 7'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                          1'b0, 1'b0, 8'h00},
                        1'b0, '0};
      dir_table[19] = '{'{i2crts_pkg::FUNC_EVENT, 7'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                          1'b0, 1'b0, 8'hFF},
                        1'b1, '{1'b1, i2crts_pkg::ACT_NACK, 8'h00, 1'b1, 8'h00, 8'hFF,
                                i2crts_pkg::ST_PENDING}};
      dir_table[20] = '{'{i2crts_pkg::FUNC_EVENT, 7'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                          1'b0, 1'b0, 8'h00},
                        1'b0, '0};
      dir_table[21] = '{'{i2crts_pkg::FUNC_EVENT, 7'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                          1'b0, 1'b0, 8'h00},
                        1'b1, '{1'b1, i2crts_pkg::ACT_NONE, 8'h00, 1'b0, 8'h00, 8'h00,
                                i2crts_pkg::ST_SUCCESS}};
      dir_table[22] = '{'{i2crts_pkg::FUNC_WRITE, 7'h55, 8'h00, 8'h00, 8'h00, 8'h00,
                          1'b0, 1'b0, 8'h00},
                        1'b1, '{1'b1, i2crts_pkg::ACT_START, 8'h00, 1'b0, 8'h00, 8'h00,
                                i2crts_pkg::ST_PENDING}};
      dir_table[23] = '{'{i2crts_pkg::FUNC_EVENT, 7'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                          1'b0, 1'b1, 8'h00},
                        1'b1, '{1'b1, i2crts_pkg::ACT_STOP, 8'h00, 1'b0, 8'h00, 8'h00,
                                i2crts_pkg::ST_PENDING}};
      dir_table[24] = '{'{i2crts_pkg::FUNC_EVENT, 7'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                          1'b0, 1'b0, 8'h00},
                        1'b1, '{1'b1, i2crts_pkg::ACT_NONE, 8'h00, 1'b0, 8'h00, 8'h00,
                                i2crts_pkg::ST_FAILED}};
   end

   // Applies one accepted request to the local state and returns the response
   // the sequencer owes for it.
   function automatic result_type predict_transfer(input cmd_type c);
      result_type r;
      r = '0;
      if (c.func == i2crts_pkg::FUNC_LOAD) begin
         if (int'(c.bidx) < i2crts_pkg::BUFFER_DEPTH_DEF) begin
            mdl_buffer[c.bidx] = c.wbyte;
            r.acc = 1'b1;
         end
      end else if (c.func == i2crts_pkg::FUNC_WRITE || c.func == i2crts_pkg::FUNC_READ) begin
         // A start is only taken while no transfer is pending.
         if (mdl_phase == SQ_IDLE) begin
            mdl_addr = {c.saddr, 1'b0};
            mdl_reg = c.raddr;
            mdl_count = c.cnt;
            mdl_pos = 8'd0;
            mdl_read = (c.func == i2crts_pkg::FUNC_READ);
            mdl_status = i2crts_pkg::ST_PENDING;
            mdl_phase = SQ_SEND_ADDR;
            r.acc = 1'b1;
            r.act = i2crts_pkg::ACT_START;
         end
      end else if (mdl_phase != SQ_IDLE) begin
         r.acc = 1'b1;
         if (c.coll) begin
            r.act = i2crts_pkg::ACT_STOP;
            mdl_phase = SQ_FAIL_END;
         end else begin
            case (mdl_phase)
               SQ_SEND_ADDR: begin
                  r.act = i2crts_pkg::ACT_SEND;
                  r.tx = mdl_addr;
                  mdl_phase = SQ_SEND_REG;
               end
               SQ_SEND_REG: begin
                  if (c.nack) begin
                     r.act = i2crts_pkg::ACT_STOP;
                     mdl_phase = SQ_FAIL_END;
                  end else begin
                     r.act = i2crts_pkg::ACT_SEND;
                     r.tx = mdl_reg;
                     mdl_phase = mdl_read ? SQ_RS_STOP : SQ_SEND_DATA;
                  end
               end
               SQ_SEND_DATA: begin
                  if (c.nack) begin
                     r.act = i2crts_pkg::ACT_STOP;
                     mdl_phase = SQ_FAIL_END;
                  end else if (mdl_pos < mdl_count) begin
                     r.act = i2crts_pkg::ACT_SEND;
                     r.tx = mdl_buffer[mdl_pos];
                     mdl_pos = mdl_pos + 8'd1;
                  end else begin
                     r.act = i2crts_pkg::ACT_STOP;
                     mdl_phase = SQ_OK_END;
                  end
               end
               SQ_RS_STOP: begin
                  r.act = i2crts_pkg::ACT_STOP;
                  mdl_phase = SQ_RS_START;
               end
               SQ_RS_START: begin
                  r.act = i2crts_pkg::ACT_START;
                  mdl_phase = SQ_READ_ADDR;
               end
               SQ_READ_ADDR: begin
                  r.act = i2crts_pkg::ACT_SEND;
                  r.tx = mdl_addr + 8'd1;
                  mdl_phase = SQ_FIRST_RX;
               end
               SQ_FIRST_RX: begin
                  if (c.nack) begin
                     r.act = i2crts_pkg::ACT_STOP;
                     mdl_phase = SQ_FAIL_END;
                  end else begin
                     r.act = i2crts_pkg::ACT_RECV;
                     mdl_phase = SQ_RX_BYTE;
                  end
               end
               SQ_RX_BYTE: begin
                  r.rxv = 1'b1;
                  r.rxi = mdl_pos;
                  r.rxd = c.rbyte;
                  mdl_pos = mdl_pos + 8'd1;
                  if (mdl_pos < mdl_count) begin
                     r.act = i2crts_pkg::ACT_ACK;
                     mdl_phase = SQ_EN_RX;
                  end else begin
                     r.act = i2crts_pkg::ACT_NACK;
                     mdl_phase = SQ_NACK_DONE;
                  end
               end
               SQ_EN_RX: begin
                  r.act = i2crts_pkg::ACT_RECV;
                  mdl_phase = SQ_RX_BYTE;
               end
               SQ_NACK_DONE: begin
                  r.act = i2crts_pkg::ACT_STOP;
                  mdl_phase = SQ_OK_END;
               end
               SQ_FAIL_END: begin
                  mdl_status = i2crts_pkg::ST_FAILED;
                  mdl_phase = SQ_IDLE;
               end
               SQ_OK_END: begin
                  mdl_status = i2crts_pkg::ST_SUCCESS;
                  mdl_phase = SQ_IDLE;
               end
               default: begin
                  mdl_status = i2crts_pkg::ST_FAILED;
                  mdl_phase = SQ_IDLE;
               end
            endcase
         end
      end
      r.st = mdl_status;
      return r;
   endfunction

   // Picks the next random request from the model state after every request
   // sent so far. While a transfer is pending it mostly sends bus events, so
   // that transfers run to their end. When idle it mostly starts a new
   // transfer, first loading every buffer slot a write will send that has not
   // been loaded yet.
   function automatic cmd_type plan_next_command();
      cmd_type c;
      cmd_type fill;
      cmd_type start_cmd;
      int unsigned roll;
      int unsigned n;
      logic reading;
      logic checked;
      c.func = i2crts_pkg::FUNC_EVENT;
      c.saddr = 7'($urandom_range(0, 127));
      c.raddr = 8'($urandom_range(0, 255));
      c.cnt = 8'($urandom_range(0, 255));
      c.bidx = 8'($urandom_range(0, 255));
      c.wbyte = 8'($urandom_range(0, 255));
      c.nack = 1'($urandom_range(0, 1));
      c.coll = 1'b0;
      c.rbyte = 8'($urandom_range(0, 255));
      if (upcoming.size() != 0) return upcoming.pop_front();
      roll = $urandom_range(0, 99);
      if (mdl_phase != SQ_IDLE) begin
         checked = (mdl_phase == SQ_SEND_REG || mdl_phase == SQ_SEND_DATA ||
                    mdl_phase == SQ_FIRST_RX);
         if (roll < 4) begin
            c.func = i2crts_pkg::FUNC_LOAD;
            loaded[c.bidx] = 1'b1;
         end else if (roll < 7) begin
            c.func = (roll == 5) ? i2crts_pkg::FUNC_READ : i2crts_pkg::FUNC_WRITE;
         end else begin
            // Long transfers are left alone so that they reach their end.
            if (checked) c.nack = (mdl_count < 8'd32) && ($urandom_range(0, 99) < 4);
            c.coll = (mdl_count < 8'd32) && ($urandom_range(0, 99) < 2);
         end
         return c;
      end
      if (roll < 12) begin
         c.func = i2crts_pkg::FUNC_LOAD;
         loaded[c.bidx] = 1'b1;
         return c;
      end
      if (roll < 20) begin
         c.coll = 1'($urandom_range(0, 1));
         return c;
      end
      transfer_count++;
      reading = 1'($urandom_range(0, 1));
      roll = $urandom_range(0, 99);
      if (transfer_count == 2) begin
         n = 255;
         reading = 1'b0;
      end else if (transfer_count == 8) begin
         n = 255;
         reading = 1'b1;
      end else if (roll < 70) begin
         n = $urandom_range(0, 3);
      end else if (roll < 95) begin
         n = $urandom_range(4, 12);
      end else begin
         n = $urandom_range(13, 40);
      end
      if (!reading) begin
         for (int i = 0; i < int'(n); i++) begin
            if (!loaded[i] || $urandom_range(0, 3) == 0) begin
               fill = c;
               fill.func = i2crts_pkg::FUNC_LOAD;
               fill.bidx = 8'(i);
               fill.wbyte = 8'($urandom_range(0, 255));
               upcoming.push_back(fill);
               loaded[i] = 1'b1;
            end
         end
      end
      start_cmd = c;
      start_cmd.func = reading ? i2crts_pkg::FUNC_READ : i2crts_pkg::FUNC_WRITE;
      start_cmd.cnt = 8'(n);
      upcoming.push_back(start_cmd);
      return upcoming.pop_front();
   endfunction

   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         failed = 1'b1;
      end
   endtask

   // Request side. Each accepted item goes through the model at the edge that
   // takes it, and only then is the next item chosen, so the generator always
   // sees the state after everything already sent. Valid only drops between
   // items, for a random gap, and never while an item waits.
   always @(posedge clock) begin : drive_requests
      result_type predicted;
      cmd_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
         mdl_phase = SQ_IDLE;
         mdl_status = i2crts_pkg::ST_SUCCESS;
         mdl_addr = 8'd0;
         mdl_reg = 8'd0;
         mdl_count = 8'd0;
         mdl_pos = 8'd0;
         mdl_read = 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            predicted = predict_transfer(req_cmd);
            awaited_results.push_back(cur_given ? cur_given_res : predicted);
            taken_items++;
         end
         if (!req_valid || req_ready) begin
            if (send_gap != 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (table_pos >= DIR_ROWS && taken_items >= ITEM_TARGET) begin
               req_valid <= 1'b0;
               stim_done <= 1'b1;
            end else if (!no_idle && $urandom_range(0, 5) == 0) begin
               send_gap = $urandom_range(0, 7);
               req_valid <= 1'b0;
            end else begin
               if (table_pos < DIR_ROWS) begin
                  nxt = dir_table[table_pos].cmd;
                  cur_given = dir_table[table_pos].given;
                  cur_given_res = dir_table[table_pos].res;
                  table_pos++;
               end else begin
                  nxt = plan_next_command();
                  cur_given = 1'b0;
               end
               req_cmd <= nxt;
               req_valid <= 1'b1;
            end
         end
         // Idling stops near the end of the run and for one stretch in every
         // five, so that back-to-back items are seen too.
         no_idle <= (taken_items + 150 >= ITEM_TARGET) || (((cycle_no / 160) % 5) == 4);
      end
   end

   // Response side. Each response item is checked against the oldest
   // prediction. Ready drops in short random bursts. Once, it stays low for a
   // long stretch, so that the output register fills and requests back up.
   always @(posedge clock) begin : check_results
      result_type want;
      result_type got;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            got = {rsp_accepted, rsp_bus_action, rsp_tx_byte, rsp_rx_valid,
                   rsp_rx_index, rsp_rx_data, rsp_transfer_status};
            if (awaited_results.size() == 0) begin
               $display("%0t: response with nothing expected, actual %p", $time, got);
               failed = 1'b1;
            end else begin
               want = awaited_results.pop_front();
               check_field("accepted", want.acc, got.acc);
               check_field("bus_action", want.act, got.act);
               check_field("tx_byte", want.tx, got.tx);
               check_field("rx_valid", want.rxv, got.rxv);
               check_field("rx_index", want.rxi, got.rxi);
               check_field("rx_data", want.rxd, got.rxd);
               check_field("transfer_status", want.st, got.st);
            end
            results_seen++;
         end
         if (stall_left != 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if (!held_off && results_seen >= 500) begin
            held_off = 1'b1;
            stall_left = HOLD_OFF - 1;
            rsp_ready <= 1'b0;
         end else if (!no_idle && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 7);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Ends the run if nothing moves on either channel for far longer than the
   // long hold-off on the response side.
   always @(posedge clock) begin : watchdog
      cycle_no <= cycle_no + 1;
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
         $display("Verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Reset is held at the start and never again. The verdict
   // comes once every request has been sent and every prediction has been
   // met, after a drain that catches any stray response.
   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      while (!(stim_done && awaited_results.size() == 0)) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (failed) begin
         $display("Verification failed");
      end else begin
         $display("Verification passed");
      end
      $finish;
   end

endmodule
